>>> rtl/alsir_pkg.sv
package alsir_pkg;

  localparam int CmdW    = 3;
  localparam int PosW    = 5;
  localparam int DataW   = 32;
  localparam int CountW  = 5;
  localparam int FIdxW   = 4;
  localparam int StatusW = 2;

  localparam logic [CmdW-1:0] CMD_INSERT = 3'd0;
  localparam logic [CmdW-1:0] CMD_REMOVE = 3'd1;
  localparam logic [CmdW-1:0] CMD_GET    = 3'd2;
  localparam logic [CmdW-1:0] CMD_UPDATE = 3'd3;
  localparam logic [CmdW-1:0] CMD_FIND   = 3'd4;
  localparam logic [CmdW-1:0] CMD_CLEAR  = 3'd5;

  localparam logic [StatusW-1:0] ST_OK    = 2'd0;
  localparam logic [StatusW-1:0] ST_FULL  = 2'd1;
  localparam logic [StatusW-1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic shift_up;
    logic shift_down;
    logic write;
  } cell_ctrl_t;

endpackage

>>> rtl/alsir_cell.sv
module alsir_cell import alsir_pkg::*; #(
  parameter int IDX_W = 5
) (
  input  logic                    clk,
  input  cell_ctrl_t              ctrl,
  input  logic [IDX_W-1:0]        idx,
  input  logic [IDX_W-1:0]        pos,
  input  logic [IDX_W-1:0]        cnt,
  input  logic signed [DataW-1:0] value,
  input  logic signed [DataW-1:0] left,
  input  logic signed [DataW-1:0] right,
  output logic signed [DataW-1:0] entry,
  output logic                    match
);

  logic signed [DataW-1:0] entry_next;

  always_comb begin
    entry_next = entry;
    if (ctrl.shift_up) begin
      if (idx > pos) begin
        entry_next = left;
      end else if (idx == pos) begin
        entry_next = value;
      end
    end else if (ctrl.shift_down) begin
      if (idx >= pos) begin
        entry_next = right;
      end
    end else if (ctrl.write && idx == pos) begin
      entry_next = value;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

  assign match = (entry == value) && (idx < cnt);

endmodule

>>> rtl/array_list_shift_insert_remove.sv
// Each accepted command passes the compare stage, then the output register.
// Throughput: one command per cycle; the shift chain moves every cell at once.
// in_ready drops only while both the compare stage and the output register
// hold results and out_ready is low.
// Reset clears the entry count and both stage valids; cell contents are kept.
module array_list_shift_insert_remove import alsir_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [CmdW-1:0]           cmd,
  input  logic [PosW-1:0]           position,
  input  logic signed [DataW-1:0]   value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [DataW-1:0]   read_value,
  output logic                      found,
  output logic [FIdxW-1:0]          found_index,
  output logic [CountW-1:0]         count,
  output logic [StatusW-1:0]        status
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int PW = (CW > PosW) ? CW : PosW;

  logic [CW-1:0]           entry_count;
  logic [CW-1:0]           entry_count_next;
  logic                    s1_valid;
  logic [CAPACITY-1:0]     s1_match;
  logic signed [DataW-1:0] s1_rd;
  logic [CountW-1:0]       s1_count;
  logic [StatusW-1:0]      s1_status;

  logic                    in_beat;
  logic                    adv;
  logic [PW-1:0]           pos_x;
  logic [PW-1:0]           cnt_x;
  logic                    full;
  logic                    in_range;
  cell_ctrl_t              ctrl;
  logic [StatusW-1:0]      st;
  logic signed [DataW-1:0] rd;
  logic signed [DataW-1:0] entries [CAPACITY];
  logic [CAPACITY-1:0]     match;
  logic [IW-1:0]           first_idx;

  assign adv      = !out_valid || out_ready;
  assign in_ready = !s1_valid || adv;
  assign in_beat  = in_valid && in_ready;

  assign pos_x    = PW'(position);
  assign cnt_x    = PW'(entry_count);
  assign full     = (32'(entry_count) >= CAPACITY);
  assign in_range = pos_x < cnt_x;

  always_comb begin
    ctrl             = '0;
    st               = ST_OK;
    rd               = '0;
    entry_count_next = entry_count;
    case (cmd)
      CMD_INSERT: begin
        if (full) begin
          st = ST_FULL;
        end else if (pos_x > cnt_x) begin
          st = ST_RANGE;
        end else begin
          ctrl.shift_up    = in_beat;
          entry_count_next = entry_count + 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (!in_range) begin
          st = ST_RANGE;
        end else begin
          ctrl.shift_down  = in_beat;
          entry_count_next = entry_count - 1'b1;
        end
      end
      CMD_GET: begin
        if (!in_range) begin
          st = ST_RANGE;
          rd = '1;
        end else begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (pos_x == PW'(i)) begin
              rd = entries[i];
            end
          end
        end
      end
      CMD_UPDATE: begin
        if (!in_range) begin
          st = ST_RANGE;
        end else begin
          ctrl.write = in_beat;
        end
      end
      CMD_CLEAR: begin
        entry_count_next = '0;
      end
      default: begin
      end
    endcase
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [DataW-1:0] left;
    logic signed [DataW-1:0] right;
    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = entries[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right = entries[g];
    end else begin : g_mid_r
      assign right = entries[g+1];
    end
    alsir_cell #(.IDX_W(PW)) u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .idx   (PW'(g)),
      .pos   (pos_x),
      .cnt   (cnt_x),
      .value (value),
      .left  (left),
      .right (right),
      .entry (entries[g]),
      .match (match[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      s1_valid    <= 1'b0;
    end else begin
      if (in_beat) begin
        entry_count <= entry_count_next;
      end
      if (in_ready) begin
        s1_valid <= in_valid;
      end
    end
    if (in_beat) begin
      s1_match  <= (cmd == CMD_FIND) ? match : '0;
      s1_rd     <= rd;
      s1_count  <= CountW'(32'(entry_count_next));
      s1_status <= st;
    end
  end

  always_comb begin
    first_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (s1_match[i]) begin
        first_idx = IW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid;
    end
    if (adv && s1_valid) begin
      read_value  <= s1_rd;
      found       <= |s1_match;
      found_index <= FIdxW'(32'(first_idx));
      count       <= s1_count;
      status      <= s1_status;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(entry_count) <= CAPACITY)
    else $error("entry count above capacity");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && out_valid && !out_ready))
    else $error("input stalled without a full pipeline");

  a_no_match_idx: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (found_index == '0))
    else $error("found_index set without a match");

  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |-> (!found && read_value == '0))
    else $error("refused insert carries data");

endmodule
